@@ sv/rsh_pkg.sv @@
// Shared types and constants for the ray-sphere nearest-hit picker.
// Used by rsh_addsub, rsh_core and ray_sphere_nearest_hit; depends on nothing.
package rsh_pkg;

  // Width of the shared adder and the wide working registers.
  localparam int W = 136;
  // Width of the multiplier operand shift register.
  localparam int MW = 68;

  localparam int MAX_SPHERES = 1024;
  localparam int CNT_W = $clog2(MAX_SPHERES + 1);
  localparam int IDX_W = 10;
  localparam int T_W = 31;

  // Step counts of the shift-add multiply, the root and the division.
  localparam logic [6:0] LEN_D = 7'd32;
  localparam logic [6:0] LEN_L = 7'd33;
  localparam logic [6:0] LEN_H = 7'd68;
  localparam logic [6:0] SQRT_STEPS = 7'd64;
  localparam logic [6:0] DIV_STEPS = 7'd31;

  // Configuration register indexes.
  localparam logic [2:0] CFG_ORIGIN_X = 3'd0;
  localparam logic [2:0] CFG_ORIGIN_Y = 3'd1;
  localparam logic [2:0] CFG_ORIGIN_Z = 3'd2;
  localparam logic [2:0] CFG_DIR_X = 3'd3;
  localparam logic [2:0] CFG_DIR_Y = 3'd4;
  localparam logic [2:0] CFG_DIR_Z = 3'd5;

  localparam logic [31:0] DIR_Z_RESET = 32'h0001_0000;
  localparam logic [T_W-1:0] T_SAT = {T_W{1'b1}};

  // Sequencer states of the arithmetic core.
  typedef enum logic [3:0] {
    C_IDLE, C_SETUP, C_MUL, C_MDONE, C_SQRT, C_NSUB, C_NADD, C_OVF, C_DIV, C_FIN
  } rsh_cst_t;

  // Product schedule of the core.
  typedef enum logic [3:0] {
    M_DXX, M_DYY, M_DZZ, M_LXD, M_LYD, M_LZD, M_LXX, M_LYY, M_LZZ, M_RR, M_HH, M_AE
  } rsh_mop_t;

  // States of the pick control in the top level.
  typedef enum logic [1:0] {
    P_IDLE, P_BUSY, P_EMIT
  } rsh_pst_t;

  // Result handed from the core to the pick control.
  typedef struct packed {
    logic           done;
    logic           hit;
    logic [T_W-1:0] t;
  } rsh_res_t;

endpackage

@@ sv/rsh_addsub.sv @@
// Shared wide adder/subtractor of the ray-sphere picker core.
// Depends on rsh_pkg for the datapath width.
module rsh_addsub
  import rsh_pkg::*;
(
  input  logic [W-1:0] x_i,
  input  logic [W-1:0] y_i,
  input  logic         sub_i,
  output logic [W-1:0] sum_o
);

  // Two's complement add, inverting the second operand for a subtract.
  assign sum_o = x_i + (sub_i ? ~y_i : y_i) + {{(W-1){1'b0}}, sub_i};

endmodule

@@ sv/rsh_core.sv @@
// Iterative sequencer that tests one sphere against the ray.
// Depends on rsh_pkg and on rsh_addsub, the single arithmetic unit it shares.
module rsh_core
  import rsh_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start_i,
  input  logic signed [32:0]    lx_i,
  input  logic signed [32:0]    ly_i,
  input  logic signed [32:0]    lz_i,
  input  logic signed [31:0]    dx_i,
  input  logic signed [31:0]    dy_i,
  input  logic signed [31:0]    dz_i,
  input  logic [T_W-1:0]        rad_i,
  output rsh_res_t              res_o
);

  rsh_cst_t st_r, st_nxt;
  rsh_mop_t op_r, op_nxt;

  logic signed [32:0] lx_r, ly_r, lz_r, lx_nxt, ly_nxt, lz_nxt;
  logic signed [31:0] dx_r, dy_r, dz_r, dx_nxt, dy_nxt, dz_nxt;
  logic [T_W-1:0]     rad_r, rad_nxt;
  logic [63:0]        a_r, a_nxt;
  logic [MW-1:0]      h_r, h_nxt, e_r, e_nxt;
  logic [W-1:0]       acc_r, acc_nxt, mc_r, mc_nxt;
  logic [MW-1:0]      mp_r, mp_nxt;
  logic [6:0]         cnt_r, cnt_nxt;
  logic [127:0]       bit_r, bit_nxt;
  logic [T_W-1:0]     q_r, q_nxt;
  logic               hit_r, hit_nxt;

  logic [W-1:0] add_x, add_y, add_sum;
  logic         add_sub;
  logic         ge;

  // Operands of the product selected by the schedule.
  logic [W-1:0]  op_mc;
  logic [MW-1:0] op_mp;
  logic [6:0]    op_len;
  logic          op_clr, op_neg;

  rsh_addsub u_add (
    .x_i   (add_x),
    .y_i   (add_y),
    .sub_i (add_sub),
    .sum_o (add_sum)
  );

  // A non-negative difference means the compare passed.
  assign ge = ~add_sum[W-1];

  // Product table: multiplicand, multiplier, its length and accumulate mode.
  always_comb begin
    op_mc  = '0;
    op_mp  = '0;
    op_len = LEN_D;
    op_clr = 1'b0;
    op_neg = 1'b0;
    unique case (op_r)
      M_DXX: begin
        op_mc = {{(W-32){dx_r[31]}}, dx_r}; op_mp = {{(MW-32){dx_r[31]}}, dx_r};
        op_clr = 1'b1;
      end
      M_DYY: begin
        op_mc = {{(W-32){dy_r[31]}}, dy_r}; op_mp = {{(MW-32){dy_r[31]}}, dy_r};
      end
      M_DZZ: begin
        op_mc = {{(W-32){dz_r[31]}}, dz_r}; op_mp = {{(MW-32){dz_r[31]}}, dz_r};
      end
      M_LXD: begin
        op_mc = {{(W-33){lx_r[32]}}, lx_r}; op_mp = {{(MW-32){dx_r[31]}}, dx_r};
        op_clr = 1'b1;
      end
      M_LYD: begin
        op_mc = {{(W-33){ly_r[32]}}, ly_r}; op_mp = {{(MW-32){dy_r[31]}}, dy_r};
      end
      M_LZD: begin
        op_mc = {{(W-33){lz_r[32]}}, lz_r}; op_mp = {{(MW-32){dz_r[31]}}, dz_r};
      end
      M_LXX: begin
        op_mc = {{(W-33){lx_r[32]}}, lx_r}; op_mp = {{(MW-33){lx_r[32]}}, lx_r};
        op_len = LEN_L; op_clr = 1'b1;
      end
      M_LYY: begin
        op_mc = {{(W-33){ly_r[32]}}, ly_r}; op_mp = {{(MW-33){ly_r[32]}}, ly_r};
        op_len = LEN_L;
      end
      M_LZZ: begin
        op_mc = {{(W-33){lz_r[32]}}, lz_r}; op_mp = {{(MW-33){lz_r[32]}}, lz_r};
        op_len = LEN_L;
      end
      M_RR: begin
        op_mc = {{(W-T_W){1'b0}}, rad_r}; op_mp = {{(MW-T_W){1'b0}}, rad_r};
        op_neg = 1'b1;
      end
      M_HH: begin
        op_mc = {{(W-MW){h_r[MW-1]}}, h_r}; op_mp = h_r;
        op_len = LEN_H; op_clr = 1'b1;
      end
      M_AE: begin
        op_mc = {{(W-64){1'b0}}, a_r}; op_mp = e_r;
        op_len = LEN_H; op_neg = 1'b1;
      end
      default: begin
        op_mc = '0;
      end
    endcase
  end

  // Operand selection of the shared adder.
  always_comb begin
    add_x   = acc_r;
    add_y   = mc_r;
    add_sub = 1'b1;
    unique case (st_r)
      C_MUL:  add_sub = op_neg ^ (cnt_r == 7'd1);
      C_SQRT: add_y = mc_r | {{(W-128){1'b0}}, bit_r};
      C_NSUB: add_x = {{(W-MW){h_r[MW-1]}}, h_r};
      C_NADD: begin
        add_x   = {{(W-MW){h_r[MW-1]}}, h_r};
        add_sub = 1'b0;
      end
      C_OVF:  add_y = {{(W-64){1'b0}}, a_r} << 31;
      default: add_sub = 1'b1;
    endcase
  end

  // Next state of the sequencer.
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      C_IDLE:  if (start_i) st_nxt = C_SETUP;
      C_SETUP: st_nxt = C_MUL;
      C_MUL:   if (cnt_r == 7'd1) st_nxt = C_MDONE;
      C_MDONE: begin
        if (op_r == M_DZZ && acc_r[63:0] == 64'd0) st_nxt = C_FIN;
        else if (op_r == M_AE) st_nxt = acc_r[W-1] ? C_FIN : C_SQRT;
        else st_nxt = C_SETUP;
      end
      C_SQRT:  if (cnt_r == 7'd1) st_nxt = C_NSUB;
      C_NSUB:  st_nxt = ge ? C_OVF : C_NADD;
      C_NADD:  st_nxt = ge ? C_OVF : C_FIN;
      C_OVF:   st_nxt = ge ? C_FIN : C_DIV;
      C_DIV:   if (cnt_r == 7'd1) st_nxt = C_FIN;
      C_FIN:   st_nxt = C_IDLE;
      default: st_nxt = C_IDLE;
    endcase
  end

  // Datapath registers.
  always_comb begin
    lx_nxt = lx_r; ly_nxt = ly_r; lz_nxt = lz_r;
    dx_nxt = dx_r; dy_nxt = dy_r; dz_nxt = dz_r;
    rad_nxt = rad_r; a_nxt = a_r; h_nxt = h_r; e_nxt = e_r;
    acc_nxt = acc_r; mc_nxt = mc_r; mp_nxt = mp_r; cnt_nxt = cnt_r;
    bit_nxt = bit_r; q_nxt = q_r; hit_nxt = hit_r; op_nxt = op_r;
    unique case (st_r)
      C_IDLE: begin
        if (start_i) begin
          lx_nxt = lx_i; ly_nxt = ly_i; lz_nxt = lz_i;
          dx_nxt = dx_i; dy_nxt = dy_i; dz_nxt = dz_i;
          rad_nxt = rad_i;
          hit_nxt = 1'b0;
          op_nxt  = M_DXX;
        end
      end
      C_SETUP: begin
        mc_nxt  = op_mc;
        mp_nxt  = op_mp;
        cnt_nxt = op_len;
        if (op_clr) acc_nxt = '0;
      end
      // One multiplier bit a cycle; the top bit carries negative weight.
      C_MUL: begin
        if (mp_r[0]) acc_nxt = add_sum;
        mc_nxt  = mc_r << 1;
        mp_nxt  = {mp_r[MW-1], mp_r[MW-1:1]};
        cnt_nxt = cnt_r - 7'd1;
      end
      C_MDONE: begin
        op_nxt = rsh_mop_t'(op_r + 4'd1);
        if (op_r == M_DZZ) a_nxt = acc_r[63:0];
        if (op_r == M_LZD) h_nxt = acc_r[MW-1:0];
        if (op_r == M_RR)  e_nxt = acc_r[MW-1:0];
        if (op_r == M_AE) begin
          mc_nxt  = '0;
          bit_nxt = {2'b01, 126'd0};
          cnt_nxt = SQRT_STEPS;
        end
      end
      // Digit-by-digit square root: mc holds the root, acc the remainder.
      C_SQRT: begin
        if (ge) begin
          acc_nxt = add_sum;
          mc_nxt  = (mc_r >> 1) | {{(W-128){1'b0}}, bit_r};
        end else begin
          mc_nxt = mc_r >> 1;
        end
        bit_nxt = bit_r >> 2;
        cnt_nxt = cnt_r - 7'd1;
      end
      // Near root first, far root when the near one is negative.
      C_NSUB, C_NADD: begin
        if (ge) acc_nxt = add_sum << 16;
      end
      C_OVF: begin
        if (ge) begin
          hit_nxt = 1'b1;
          q_nxt   = T_SAT;
        end else begin
          mc_nxt  = {{(W-64){1'b0}}, a_r} << 30;
          cnt_nxt = DIV_STEPS;
          q_nxt   = '0;
        end
      end
      // Restoring division, one quotient bit a cycle.
      C_DIV: begin
        if (ge) acc_nxt = add_sum;
        q_nxt   = {q_r[T_W-2:0], ge};
        mc_nxt  = mc_r >> 1;
        cnt_nxt = cnt_r - 7'd1;
        if (cnt_r == 7'd1) hit_nxt = 1'b1;
      end
      default: begin
        q_nxt = q_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= C_IDLE;
      op_r  <= M_DXX;
      hit_r <= 1'b0;
    end else begin
      st_r  <= st_nxt;
      op_r  <= op_nxt;
      hit_r <= hit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lx_r <= lx_nxt; ly_r <= ly_nxt; lz_r <= lz_nxt;
    dx_r <= dx_nxt; dy_r <= dy_nxt; dz_r <= dz_nxt;
    rad_r <= rad_nxt; a_r <= a_nxt; h_r <= h_nxt; e_r <= e_nxt;
    acc_r <= acc_nxt; mc_r <= mc_nxt; mp_r <= mp_nxt; cnt_r <= cnt_nxt;
    bit_r <= bit_nxt; q_r <= q_nxt;
  end

  // Result of the finished sphere.
  always_comb begin
    res_o.done = (st_r == C_FIN);
    res_o.hit  = hit_r;
    res_o.t    = q_r;
  end

endmodule

@@ sv/ray_sphere_nearest_hit.sv @@
// Top level of the ray-sphere nearest-hit picker: configuration, pick state and streams.
// Depends on rsh_pkg and rsh_core.
//
// Use: write the ray origin and direction (Q16.16) through cfg_we/cfg_addr/cfg_wdata
// while the block is idle, then stream spheres on the in_ channel, one per transfer,
// with in_tlast on the final sphere of a pick. The block keeps the nearest hit; on the
// transfer marked last it offers one result on the out_ channel (hit flag in
// out_tuser, index and distance in out_tdata) and clears its pick state.
// The time a tested sphere keeps the core busy is set by the single shared adder:
// twelve shift-add products of 32 to 68 steps with a setup and a finish state each,
// a 64-step square root and a 31-step division. Taking the far root adds a state, and
// a saturating distance skips the division. A zero direction ends the test after the
// third product and a negative discriminant after the twelfth, before the root.
// in_tready is high only while no sphere is being worked on; a sphere beyond the
// 1024th of a pick is not tested.
// The result sits in an output register; if the receiver stalls, the next pick's
// spheres are still taken, and only a further last transfer waits for the slot.
// Reset (rst_n low at a clock edge) restores the default ray, pointing along +z,
// clears the pick state and drops out_tvalid.
module ray_sphere_nearest_hit
  import rsh_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_addr,
  input  logic [31:0]  cfg_wdata,
  input  logic         in_tvalid,
  output logic         in_tready,
  // center_x [31:0], center_y [63:32], center_z [95:64], radius [126:96], pad [127]
  input  logic [127:0] in_tdata,
  input  logic         in_tlast,
  output logic         out_tvalid,
  input  logic         out_tready,
  // best_index [9:0], hit_distance [40:10], pad [47:41]
  output logic [47:0]  out_tdata,
  // hit [0]
  output logic         out_tuser
);

  logic signed [31:0] org_x_r, org_y_r, org_z_r, dir_x_r, dir_y_r, dir_z_r;

  rsh_pst_t st_r, st_nxt;
  logic [31:0]      near_t_r, near_t_nxt;
  logic [IDX_W-1:0] near_idx_r, near_idx_nxt, cur_idx_r;
  logic             found_r, found_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             last_r;
  logic             out_tvalid_r, out_tuser_r;
  logic [47:0]      out_tdata_r;

  logic     accept, in_range, core_start, slot_free, out_load;
  rsh_res_t res;
  logic signed [32:0] lx, ly, lz;

  assign accept    = in_tvalid & in_tready;
  assign in_range  = (count_r < CNT_W'(MAX_SPHERES));
  assign slot_free = ~out_tvalid_r | out_tready;

  // Centre relative to the ray origin.
  assign lx = 33'(signed'(in_tdata[31:0]))  - 33'(org_x_r);
  assign ly = 33'(signed'(in_tdata[63:32])) - 33'(org_y_r);
  assign lz = 33'(signed'(in_tdata[95:64])) - 33'(org_z_r);

  rsh_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .start_i (core_start),
    .lx_i    (lx),
    .ly_i    (ly),
    .lz_i    (lz),
    .dx_i    (dir_x_r),
    .dy_i    (dir_y_r),
    .dz_i    (dir_z_r),
    .rad_i   (in_tdata[126:96]),
    .res_o   (res)
  );

  // Configuration registers; writes to unused indexes are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      org_x_r <= '0; org_y_r <= '0; org_z_r <= '0;
      dir_x_r <= '0; dir_y_r <= '0; dir_z_r <= DIR_Z_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_ORIGIN_X: org_x_r <= cfg_wdata;
        CFG_ORIGIN_Y: org_y_r <= cfg_wdata;
        CFG_ORIGIN_Z: org_z_r <= cfg_wdata;
        CFG_DIR_X:    dir_x_r <= cfg_wdata;
        CFG_DIR_Y:    dir_y_r <= cfg_wdata;
        CFG_DIR_Z:    dir_z_r <= cfg_wdata;
        default:      org_x_r <= org_x_r;
      endcase
    end
  end

  // Next state of the pick control.
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      P_IDLE: begin
        if (accept) begin
          if (in_range) st_nxt = P_BUSY;
          else if (in_tlast) st_nxt = P_EMIT;
        end
      end
      P_BUSY: if (res.done) st_nxt = last_r ? P_EMIT : P_IDLE;
      P_EMIT: if (slot_free) st_nxt = P_IDLE;
      default: st_nxt = P_IDLE;
    endcase
  end

  // Handshake and control outputs of the pick control.
  always_comb begin
    in_tready  = 1'b0;
    core_start = 1'b0;
    out_load   = 1'b0;
    unique case (st_r)
      P_IDLE:  begin
        in_tready  = 1'b1;
        core_start = in_tvalid & in_range;
      end
      P_EMIT:  out_load = slot_free;
      default: in_tready = 1'b0;
    endcase
  end

  // Nearest-hit bookkeeping; strict less-than keeps the earliest of equal hits.
  always_comb begin
    near_t_nxt   = near_t_r;
    near_idx_nxt = near_idx_r;
    found_nxt    = found_r;
    count_nxt    = count_r;
    if (accept && in_range) count_nxt = count_r + CNT_W'(1);
    if (st_r == P_BUSY && res.done && res.hit && {1'b0, res.t} < near_t_r) begin
      near_t_nxt   = {1'b0, res.t};
      near_idx_nxt = cur_idx_r;
      found_nxt    = 1'b1;
    end
    if (out_load) begin
      near_t_nxt   = '1;
      near_idx_nxt = '0;
      found_nxt    = 1'b0;
      count_nxt    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= P_IDLE;
      near_t_r     <= '1;
      near_idx_r   <= '0;
      found_r      <= 1'b0;
      count_r      <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      st_r       <= st_nxt;
      near_t_r   <= near_t_nxt;
      near_idx_r <= near_idx_nxt;
      found_r    <= found_nxt;
      count_r    <= count_nxt;
      if (out_load) out_tvalid_r <= 1'b1;
      else if (out_tready) out_tvalid_r <= 1'b0;
    end
  end

  // Per-sphere context and the output register.
  always_ff @(posedge clk) begin
    if (accept) begin
      last_r    <= in_tlast;
      cur_idx_r <= count_r[IDX_W-1:0];
    end
    if (out_load) begin
      out_tuser_r <= found_r;
      out_tdata_r <= {7'd0, found_r ? near_t_r[T_W-1:0] : '0,
                      found_r ? near_idx_r : '0};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

`ifndef SYNTHESIS
  a_done_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
    res.done |-> st_r == P_BUSY) else $error("core finished outside a sphere test");
  a_found_sets_t: assert property (@(posedge clk) disable iff (!rst_n)
    !found_r |-> near_t_r == 32'hFFFF_FFFF) else $error("nearest distance without a hit");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_SPHERES)) else $error("sphere count beyond limit");
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == 48'd0) else $error("miss result not zero");
`endif

endmodule
